[hw/rtl/ir_frame_pixel_demux_unit_macros.svh]
// Assertion macros used by the checker file of the frame pixel demux.
`ifndef IR_FRAME_PIXEL_DEMUX_UNIT_MACROS_SVH
`define IR_FRAME_PIXEL_DEMUX_UNIT_MACROS_SVH

// Clocked check, switched off while reset is high.
`define IR_FDM_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("ir_fdm check failed");

// Clocked check that also holds across reset.
`define IR_FDM_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("ir_fdm check failed");

`endif

[hw/rtl/ir_fdm_pkg.sv]
// Package: constants, register codes and queue word type of the frame pixel demux.
package ir_fdm_pkg;

  // Default geometry
  localparam int CHANNELS_DEF      = 7;
  localparam int PIXELS_PER_SEG_DEF = 183;
  localparam int CHANNEL_STRIDE_DEF = 192;
  localparam int FIRST_SAMPLE_DEF  = 113;
  localparam int MAX_LINES_DEF     = 3400;
  localparam int SEGMENTS_DEF      = 36;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int CH_W     = 3;
  localparam int LINE_W   = 12;
  localparam int COL_W    = 12;
  localparam int PIXEL_W  = 16;
  localparam int SAMPLE_W = 10;
  localparam int POS_W    = 11;
  localparam int RAW_LINE_W = 13;
  localparam int SEG_W    = 6;
  localparam int OFF_W    = 8;
  localparam int LIMIT_W  = 17;
  localparam int GAIN_W   = 6;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = LIMIT_W;

  // Frame layout
  localparam logic [POS_W-1:0] DATA_START      = 11'd5;
  localparam logic [POS_W-1:0] LINE_HI_POS     = 11'd8;
  localparam logic [POS_W-1:0] LINE_LO_POS     = 11'd9;
  localparam logic [POS_W-1:0] SEGMENT_POS     = 11'd10;
  localparam logic [POS_W-1:0] DECODED_SAMPLES = 11'd1548;
  localparam logic [POS_W-1:0] POS_MAX         = 11'd2047;
  localparam logic [LIMIT_W-1:0] COUNT_MAX     = 17'd131071;

  // Register reset values
  localparam logic [LIMIT_W-1:0] FRAME_LIMIT_RST = 17'd122400;
  localparam logic [GAIN_W-1:0]  PIXEL_GAIN_RST  = 6'd60;

  // Largest product of a 10-bit sample and a 6-bit gain
  localparam logic [PIXEL_W-1:0] PIXEL_MAX = 16'd64449;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_LIMIT = 1'b0,
    REG_PIXEL_GAIN  = 1'b1
  } cfg_reg_t;

  // Unpacking phase within a five-byte group
  typedef enum logic [2:0] {
    PH_LOAD  = 3'd0,
    PH_S0    = 3'd1,
    PH_S1    = 3'd2,
    PH_S2    = 3'd3,
    PH_S3    = 3'd4
  } phase_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [LINE_W-1:0]   line;
    logic [SEG_W-2:0]    seg_half;
    logic [OFF_W-1:0]    offset;
    logic [SAMPLE_W-1:0] sample;
  } pix_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

endpackage

[hw/rtl/ir_fdm_ifs.sv]
// Interfaces: frame byte channel and pixel result channel.
interface ir_fdm_byte_if import ir_fdm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              frame_start;

  modport source(output valid, frame_byte, frame_start, input ready);
  modport sink(input valid, frame_byte, frame_start, output ready);
endinterface

interface ir_fdm_pix_if import ir_fdm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CH_W-1:0]    channel;
  logic [LINE_W-1:0]  line;
  logic [COL_W-1:0]   column;
  logic [PIXEL_W-1:0] pixel;

  modport source(output valid, channel, line, column, pixel, input ready);
  modport sink(input valid, channel, line, column, pixel, output ready);
endinterface

[hw/rtl/ir_frame_pixel_demux_unit.sv]
// Top level: infrared frame pixel demultiplexer with configuration registers.
// Takes one byte per cycle while ready (frame_start marks byte 0), reads the
// 13-bit line counter from bytes 8-9 and the 6-bit segment from byte 10, and
// unpacks four 10-bit samples per five bytes from byte 5 (samples 0..1547).
// Samples inside the channel windows (CHANNELS windows, PIXELS_PER_SEGMENT
// wide, CHANNEL_STRIDE apart, first at FIRST_SAMPLE) leave as one word with
// channel, line, column = (segment/2)*PIXELS_PER_SEGMENT + offset and
// pixel = sample * pixel_gain. Frames with an odd segment, a segment of
// SEGMENTS or more, or a line of MAX_LINES or more give no words; once more
// than frame_limit frames have been taken, new frames are dropped whole.
// Rate: one byte per clock while byte_in.ready is high. The front classifies a
// byte in the cycle it is taken; a four-word queue feeds the back, which does
// the gain multiply and column sum combinationally into the output register.
// A word is held in a queue entry and then in the output register.
// byte_in.ready only falls when the queue is full, i.e. when the sink has stalled.
// Configuration: write cfg_data to register cfg_index (0 frame_limit,
// 1 pixel_gain) with cfg_we, while no word is in flight.
module ir_frame_pixel_demux_unit import ir_fdm_pkg::*; #(
  parameter int CHANNELS           = CHANNELS_DEF,
  parameter int PIXELS_PER_SEGMENT = PIXELS_PER_SEG_DEF,
  parameter int CHANNEL_STRIDE     = CHANNEL_STRIDE_DEF,
  parameter int FIRST_SAMPLE       = FIRST_SAMPLE_DEF,
  parameter int MAX_LINES          = MAX_LINES_DEF,
  parameter int SEGMENTS           = SEGMENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  ir_fdm_byte_if.sink           byte_in,
  ir_fdm_pix_if.source          pix_out
);

  // configuration registers
  logic [LIMIT_W-1:0] frame_limit;
  logic [GAIN_W-1:0]  pixel_gain;

  // queue hookup
  logic        push;
  pix_word_t   push_word;
  logic        pop;
  pix_word_t   pop_word;
  queue_stat_t q_stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_limit <= FRAME_LIMIT_RST;
      pixel_gain  <= PIXEL_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_FRAME_LIMIT: frame_limit <= cfg_data[LIMIT_W-1:0];
        REG_PIXEL_GAIN:  pixel_gain  <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // front: header tracking, unpacking and window selection
  ir_fdm_front #(
    .CHANNELS           (CHANNELS),
    .PIXELS_PER_SEGMENT (PIXELS_PER_SEGMENT),
    .CHANNEL_STRIDE     (CHANNEL_STRIDE),
    .FIRST_SAMPLE       (FIRST_SAMPLE),
    .MAX_LINES          (MAX_LINES),
    .SEGMENTS           (SEGMENTS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .frame_limit (frame_limit),
    .byte_in     (byte_in),
    .q_stat      (q_stat),
    .push        (push),
    .push_word   (push_word)
  );

  // decouples the byte side from output stalls
  ir_fdm_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .pop_word  (pop_word),
    .q_stat    (q_stat)
  );

  // back: gain, column and output register
  ir_fdm_back #(
    .PIXELS_PER_SEGMENT (PIXELS_PER_SEGMENT)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .pixel_gain (pixel_gain),
    .q_stat     (q_stat),
    .pop_word   (pop_word),
    .pop        (pop),
    .pix_out    (pix_out)
  );

endmodule

[hw/rtl/ir_fdm_front.sv]
// Front: accepts frame bytes, tracks frame header, unpacks samples, picks window samples.
module ir_fdm_front import ir_fdm_pkg::*; #(
  parameter int CHANNELS           = CHANNELS_DEF,
  parameter int PIXELS_PER_SEGMENT = PIXELS_PER_SEG_DEF,
  parameter int CHANNEL_STRIDE     = CHANNEL_STRIDE_DEF,
  parameter int FIRST_SAMPLE       = FIRST_SAMPLE_DEF,
  parameter int MAX_LINES          = MAX_LINES_DEF,
  parameter int SEGMENTS           = SEGMENTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [LIMIT_W-1:0] frame_limit,
  ir_fdm_byte_if.sink        byte_in,
  input  queue_stat_t        q_stat,
  output logic               push,
  output pix_word_t          push_word
);

  logic [POS_W-1:0]      byte_position;
  logic [RAW_LINE_W-1:0] line_value;
  logic [SEG_W-1:0]      segment_value;
  logic [BYTE_W-1:0]     carry_bits;
  logic [POS_W-1:0]      sample_index;
  logic [LIMIT_W-1:0]    frame_count;
  logic                  frame_active;
  phase_t                phase;
  logic [CH_W-1:0]       win_ch;
  logic [OFF_W-1:0]      win_off;

  logic                  accept;
  logic                  start;
  logic                  ignore_start;
  logic                  proc;
  logic [POS_W-1:0]      cur;
  logic [BYTE_W-1:0]     b;
  logic [RAW_LINE_W-1:0] line_next;
  logic [SEG_W-1:0]      segment_next;
  logic                  decoding;
  logic                  have;
  logic [SAMPLE_W-1:0]   sample;
  logic [BYTE_W-1:0]     carry_next;
  phase_t                phase_next;
  logic                  frame_ok;
  logic                  past_first;
  logic                  in_win;

  assign byte_in.ready = !q_stat.full;
  assign accept        = byte_in.valid && byte_in.ready;
  assign start         = byte_in.frame_start;
  assign b             = byte_in.frame_byte;
  assign ignore_start  = frame_count > frame_limit;
  assign proc          = accept && (start ? !ignore_start : frame_active);
  assign cur           = start ? '0 : byte_position;

  // header fields, taking effect for a sample decoded from the same byte
  always_comb begin
    line_next    = line_value;
    segment_next = segment_value;
    if (start) begin
      line_next    = '0;
      segment_next = '0;
    end else if (cur == LINE_HI_POS) begin
      line_next = {b[4:0], line_value[7:0]};
    end else if (cur == LINE_LO_POS) begin
      line_next = {line_value[12:8], b};
    end else if (cur == SEGMENT_POS) begin
      segment_next = b[SEG_W-1:0];
    end
  end

  assign decoding = !start && (cur >= DATA_START) && (sample_index < DECODED_SAMPLES);

  // five bytes carry four 10-bit samples, msb first
  always_comb begin
    sample     = '0;
    carry_next = carry_bits;
    have       = 1'b0;
    phase_next = PH_LOAD;
    case (phase)
      PH_LOAD: begin
        carry_next = b;
        phase_next = PH_S0;
      end
      PH_S0: begin
        sample     = {carry_bits, b[7:6]};
        carry_next = {2'b00, b[5:0]};
        have       = 1'b1;
        phase_next = PH_S1;
      end
      PH_S1: begin
        sample     = {carry_bits[5:0], b[7:4]};
        carry_next = {4'b0000, b[3:0]};
        have       = 1'b1;
        phase_next = PH_S2;
      end
      PH_S2: begin
        sample     = {carry_bits[3:0], b[7:2]};
        carry_next = {6'b000000, b[1:0]};
        have       = 1'b1;
        phase_next = PH_S3;
      end
      PH_S3: begin
        sample     = {carry_bits[1:0], b};
        carry_next = '0;
        have       = 1'b1;
        phase_next = PH_LOAD;
      end
      default: begin
        phase_next = PH_LOAD;
      end
    endcase
  end

  assign frame_ok = !segment_next[0] && (segment_next < SEG_W'(SEGMENTS))
                    && (line_next < RAW_LINE_W'(MAX_LINES));
  assign past_first = sample_index >= POS_W'(FIRST_SAMPLE);
  assign in_win     = past_first && (win_ch < CH_W'(CHANNELS))
                      && (win_off < OFF_W'(PIXELS_PER_SEGMENT));

  assign push = proc && decoding && have && frame_ok && in_win;

  always_comb begin
    push_word          = '0;
    push_word.channel  = win_ch;
    push_word.line     = line_next[LINE_W-1:0];
    push_word.seg_half = segment_next[SEG_W-1:1];
    push_word.offset   = win_off;
    push_word.sample   = sample;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
      line_value    <= '0;
      segment_value <= '0;
      carry_bits    <= '0;
      sample_index  <= '0;
      frame_count   <= '0;
      frame_active  <= 1'b0;
      phase         <= PH_LOAD;
      win_ch        <= '0;
      win_off       <= '0;
    end else if (accept && start && ignore_start) begin
      frame_active <= 1'b0;
    end else if (proc) begin
      byte_position <= (cur < POS_MAX) ? cur + 1'b1 : POS_MAX;
      line_value    <= line_next;
      segment_value <= segment_next;
      if (start) begin
        frame_active <= 1'b1;
        if (frame_count < COUNT_MAX) begin
          frame_count <= frame_count + 1'b1;
        end
        carry_bits   <= '0;
        sample_index <= '0;
        phase        <= PH_LOAD;
        win_ch       <= '0;
        win_off      <= '0;
      end else if (decoding) begin
        carry_bits <= carry_next;
        phase      <= phase_next;
        if (have) begin
          sample_index <= sample_index + 1'b1;
          // window position follows the sample index from the first window on
          if (past_first) begin
            if (win_off == OFF_W'(CHANNEL_STRIDE - 1)) begin
              win_off <= '0;
              if (win_ch < CH_W'(CHANNELS)) begin
                win_ch <= win_ch + 1'b1;
              end
            end else begin
              win_off <= win_off + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

[hw/rtl/ir_fdm_queue.sv]
// Queue: short word queue between front and back.
module ir_fdm_queue import ir_fdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  pix_word_t   push_word,
  input  logic        pop,
  output pix_word_t   pop_word,
  output queue_stat_t q_stat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  pix_word_t          entries [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign q_stat.full  = count == CNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_word     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/ir_fdm_back.sv]
// Back: scales samples, forms column, holds the result word for the sink.
module ir_fdm_back import ir_fdm_pkg::*; #(
  parameter int PIXELS_PER_SEGMENT = PIXELS_PER_SEG_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [GAIN_W-1:0] pixel_gain,
  input  queue_stat_t       q_stat,
  input  pix_word_t         pop_word,
  output logic              pop,
  ir_fdm_pix_if.source      pix_out
);

  localparam int COL_FULL_W = 14;

  logic [COL_FULL_W-1:0] col_full;
  logic [PIXEL_W-1:0]    pixel_full;
  logic                  out_valid;

  assign pop = !q_stat.empty && (!out_valid || pix_out.ready);

  assign col_full = COL_FULL_W'(pop_word.seg_half) * COL_FULL_W'(PIXELS_PER_SEGMENT)
                    + COL_FULL_W'(pop_word.offset);
  assign pixel_full = PIXEL_W'(pop_word.sample) * PIXEL_W'(pixel_gain);

  assign pix_out.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      pix_out.channel <= pop_word.channel;
      pix_out.line    <= pop_word.line;
      pix_out.column  <= col_full[COL_W-1:0];
      pix_out.pixel   <= pixel_full;
    end
  end

endmodule

[hw/rtl/ir_fdm_checker.sv]
// Checker: port-level checks on the pixel output, bound to the top level.
`include "ir_frame_pixel_demux_unit_macros.svh"

module ir_fdm_checker import ir_fdm_pkg::*; #(
  parameter int CHANNELS  = CHANNELS_DEF,
  parameter int MAX_LINES = MAX_LINES_DEF
) (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [CH_W-1:0]    out_channel,
  input logic [LINE_W-1:0]  out_line,
  input logic [COL_W-1:0]   out_column,
  input logic [PIXEL_W-1:0] out_pixel
);

  // whole output word, for the hold check
  logic [CH_W+LINE_W+COL_W+PIXEL_W-1:0] out_all;

  assign out_all = {out_channel, out_line, out_column, out_pixel};

  `IR_FDM_ASSERT(a_stall_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_all))
  `IR_FDM_ASSERT(a_channel_range, clk, rst, out_valid |-> out_channel < CH_W'(CHANNELS))
  `IR_FDM_ASSERT(a_line_range, clk, rst, out_valid |-> RAW_LINE_W'(out_line) < RAW_LINE_W'(MAX_LINES))
  `IR_FDM_ASSERT(a_pixel_range, clk, rst, out_valid |-> out_pixel <= PIXEL_MAX)
  `IR_FDM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !out_valid)

endmodule

bind ir_frame_pixel_demux_unit ir_fdm_checker #(
  .CHANNELS  (CHANNELS),
  .MAX_LINES (MAX_LINES)
) u_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (pix_out.valid),
  .out_ready   (pix_out.ready),
  .out_channel (pix_out.channel),
  .out_line    (pix_out.line),
  .out_column  (pix_out.column),
  .out_pixel   (pix_out.pixel)
);
